// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// clocked assertion helpers used by the table core design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sknt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sknt_pkg
// shared constants and types of the sorted key node table
// ----------------------------------------------------------------------------
package sknt_pkg;

    localparam int NODE_ORDER = 16;
    localparam int IDX_W      = $clog2(NODE_ORDER);
    localparam int CNT_W      = $clog2(NODE_ORDER + 1);
    localparam int KEY_W      = 160;
    localparam int OUT_W      = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [KEY_W-1:0] wr_data;
    } ram_req_t;

    typedef struct packed {
        logic [OUT_W-1:0] place;
        logic             found;
        logic [OUT_W-1:0] entry_total;
        logic             is_full_flag;
        logic             rejected;
    } result_t;

endpackage

// ===== design/sknt_key_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sknt_key_ram
// key store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module sknt_key_ram import sknt_pkg::*; (
    input  logic             aclk,
    input  ram_req_t         req,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [NODE_ORDER];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sknt_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sknt_seq
// item sequencer: binary search, shift-up and key write against the key ram
// ----------------------------------------------------------------------------
module sknt_seq import sknt_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_op,
    input  logic [63:0]      s_key_hi,
    input  logic [63:0]      s_key_mid,
    input  logic [31:0]      s_key_lo,
    output ram_req_t         ram_req,
    input  logic [KEY_W-1:0] ram_rd_data,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SRCH_RD  = 7'b0000010,
        ST_SRCH_CMP = 7'b0000100,
        ST_FIND_CMP = 7'b0001000,
        ST_SHIFT    = 7'b0010000,
        ST_WRKEY    = 7'b0100000,
        ST_RESP     = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0] span_reg, span_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] dst_reg, dst_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_addr_reg, pend_addr_next;
    logic             found_reg, found_next;
    logic             rej_reg, rej_next;

    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] probe;
    logic [CNT_W-1:0] dst_dec;
    logic             full;
    logic             less;

    assign half    = span_reg >> 1;
    assign probe   = first_reg + half;
    assign dst_dec = dst_reg - CNT_W'(1);
    assign full    = (count_reg == CNT_W'(NODE_ORDER));
    assign less    = (ram_rd_data < key_reg);

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        first_next     = first_reg;
        span_next      = span_reg;
        count_next     = count_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        found_next     = found_reg;
        rej_next       = rej_reg;
        ram_req        = '0;
        s_ready        = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_op;
                    key_next   = {s_key_hi, s_key_mid, s_key_lo};
                    found_next = 1'b0;
                    rej_next   = 1'b0;
                    if (s_op == OP_APPEND) begin
                        first_next = count_reg;
                        rej_next   = full;
                        state_next = full ? ST_RESP : ST_WRKEY;
                    end else begin
                        first_next = '0;
                        span_next  = count_reg;
                        state_next = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_RD: begin
                if (span_reg != '0) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = probe[IDX_W-1:0];
                    state_next      = ST_SRCH_CMP;
                end else if (op_reg == OP_INSERT) begin
                    if (full) begin
                        rej_next   = 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        dst_next   = count_reg;
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT;
                    end
                end else if (first_reg < count_reg) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = first_reg[IDX_W-1:0];
                    state_next      = ST_FIND_CMP;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_SRCH_CMP: begin
                if (less) begin
                    first_next = probe + CNT_W'(1);
                    span_next  = span_reg - half - CNT_W'(1);
                end else begin
                    span_next = half;
                end
                state_next = ST_SRCH_RD;
            end
            ST_FIND_CMP: begin
                found_next = (ram_rd_data == key_reg);
                state_next = ST_RESP;
            end
            ST_SHIFT: begin
                // write of the entry read last cycle overlaps the next read
                if (pend_reg) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = pend_addr_reg;
                    ram_req.wr_data = ram_rd_data;
                end
                if (dst_reg > first_reg) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = dst_dec[IDX_W-1:0];
                    pend_next       = 1'b1;
                    pend_addr_next  = dst_reg[IDX_W-1:0];
                    dst_next        = dst_dec;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_WRKEY;
                end
            end
            ST_WRKEY: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = first_reg[IDX_W-1:0];
                ram_req.wr_data = key_reg;
                count_next      = count_reg + CNT_W'(1);
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.place        = OUT_W'(first_reg);
        res.found        = found_reg;
        res.entry_total  = OUT_W'(count_reg);
        res.is_full_flag = full;
        res.rejected     = rej_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        first_reg     <= first_next;
        span_reg      <= span_next;
        dst_reg       <= dst_next;
        pend_addr_reg <= pend_addr_next;
        found_reg     <= found_next;
        rej_reg       <= rej_next;
    end

endmodule

// ===== design/sorted_key_node_table_core.sv =====
`timescale 1ns / 1ps
// flow: append writes the key, or goes straight to the result when refused;
//   lookup and insert run a binary search, a read and a compare per step
//   (up to 5 steps for 16 entries); lookup of a used place adds a compare
//   read, insert shifts each entry above the place up, then writes the key
// throughput: one item at a time, taken only while the sequencer is idle
// reset: entry count cleared, key ram contents undefined, no clearing pass
// ----------------------------------------------------------------------------
// sorted_key_node_table_core
// sorted 160-bit key table of one tree node with insert, append and lookup
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_key_node_table_core import sknt_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_op,
    input  logic [63:0]      s_key_hi,
    input  logic [63:0]      s_key_mid,
    input  logic [31:0]      s_key_lo,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [OUT_W-1:0] m_place,
    output logic             m_found,
    output logic [OUT_W-1:0] m_entry_total,
    output logic             m_is_full_flag,
    output logic             m_rejected
);

    ram_req_t         ram_req;
    logic [KEY_W-1:0] ram_rd_data;
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             m_valid_reg;
    result_t          out_reg;

    sknt_key_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    sknt_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_key_hi    (s_key_hi),
        .s_key_mid   (s_key_mid),
        .s_key_lo    (s_key_lo),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_place        = out_reg.place;
    assign m_found        = out_reg.found;
    assign m_entry_total  = out_reg.entry_total;
    assign m_is_full_flag = out_reg.is_full_flag;
    assign m_rejected     = out_reg.rejected;

    `ASSERT_IMPLY(a_count_range, m_valid, m_entry_total <= OUT_W'(NODE_ORDER), "count out of range")
    `ASSERT_IMPLY(a_reject_full, m_valid && m_rejected, m_is_full_flag && !m_found, "reject without full")
    `ASSERT_IMPLY(a_found_used, m_valid && m_found, m_place < m_entry_total, "found beyond used entries")
    `ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "second item taken while busy")

endmodule

// ===== tb/sorted_key_node_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_node_table_core_tb
// drives insert, append, lookup and unused-op transfers into the node key
// table, checks each result against a fixed value or a behavioral copy of
// the table, with random stalls on both channels, stall-free in the middle
// ----------------------------------------------------------------------------
module sorted_key_node_table_core_tb;
    import sknt_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         DIRECTED_COUNT = 18;
    localparam int         RANDOM_ITEMS   = 1400;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         DRAIN_CYCLES   = 40;

    localparam logic [63:0] ALL64 = {64{1'b1}};
    localparam logic [31:0] ALL32 = {32{1'b1}};
    localparam logic [63:0] M_HI  = 64'h7F3A_1C00_9E55_0042;
    localparam logic [63:0] M_MID = 64'h0123_4567_89AB_CDEF;
    localparam logic [31:0] M_LO  = 32'h8000_0001;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] mid;
        logic [31:0] lo;
    } node_key_t;

    typedef struct packed {
        logic [1:0] op;
        node_key_t  key;
        logic       typed;
        result_t    want;
    } probe_row_t;

    localparam probe_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{OP_LOOKUP, '{64'h0, 64'h0, 32'h0},       1'b1, '{5'd0, 1'b0, 5'd0, 1'b0, 1'b0}},
        '{OP_LOOKUP, '{ALL64, ALL64, ALL32},       1'b1, '{5'd0, 1'b0, 5'd0, 1'b0, 1'b0}},
        '{OP_UNUSED, '{M_HI, M_MID, M_LO},         1'b1, '{5'd0, 1'b0, 5'd0, 1'b0, 1'b0}},
        '{OP_INSERT, '{M_HI, M_MID, M_LO},         1'b1, '{5'd0, 1'b0, 5'd1, 1'b0, 1'b0}},
        '{OP_LOOKUP, '{M_HI, M_MID, M_LO},         1'b1, '{5'd0, 1'b1, 5'd1, 1'b0, 1'b0}},
        // lower bound past the last used entry
        '{OP_LOOKUP, '{ALL64, ALL64, ALL32},       1'b1, '{5'd1, 1'b0, 5'd1, 1'b0, 1'b0}},
        // shift starting at place zero
        '{OP_INSERT, '{64'h0, 64'h0, 32'h0},       1'b1, '{5'd0, 1'b0, 5'd2, 1'b0, 1'b0}},
        '{OP_LOOKUP, '{64'h0, 64'h0, 32'h0},       1'b1, '{5'd0, 1'b1, 5'd2, 1'b0, 1'b0}},
        '{OP_LOOKUP, '{M_HI, M_MID, M_LO},         1'b1, '{5'd1, 1'b1, 5'd2, 1'b0, 1'b0}},
        '{OP_APPEND, '{ALL64, ALL64, ALL32},       1'b1, '{5'd2, 1'b0, 5'd3, 1'b0, 1'b0}},
        '{OP_INSERT, '{M_HI, M_MID, M_LO - 32'd1}, 1'b0, '0},
        '{OP_INSERT, '{M_HI, M_MID + 64'd1, 32'h0}, 1'b0, '0},
        '{OP_LOOKUP, '{M_HI, M_MID, M_LO + 32'd1}, 1'b0, '0},
        // append out of order leaves the table unsorted
        '{OP_APPEND, '{64'h1, ALL64, ALL32},       1'b0, '0},
        '{OP_LOOKUP, '{64'h1, ALL64, ALL32},       1'b0, '0},
        '{OP_UNUSED, '{M_HI, M_MID, M_LO},         1'b0, '0},
        '{OP_INSERT, '{ALL64, ALL64, ALL32},       1'b0, '0},
        '{OP_LOOKUP, '{ALL64, ALL64, ALL32 - 32'd1}, 1'b0, '0}
    };

    logic             aclk;
    logic             aresetn    = 1'b0;
    logic             s_valid    = 1'b0;
    logic             s_ready;
    logic [1:0]       s_op       = OP_LOOKUP;
    logic [63:0]      s_key_hi   = '0;
    logic [63:0]      s_key_mid  = '0;
    logic [31:0]      s_key_lo   = '0;
    logic             m_valid;
    logic             m_ready    = 1'b0;
    logic [OUT_W-1:0] m_place;
    logic             m_found;
    logic [OUT_W-1:0] m_entry_total;
    logic             m_is_full_flag;
    logic             m_rejected;

    logic             stall_free = 1'b0;
    node_key_t        table_keys [NODE_ORDER];
    int unsigned      table_count = 0;
    result_t          pending_results [$];
    int unsigned      mismatch_count = 0;
    int unsigned      results_seen = 0;
    int unsigned      idle_cycles = 0;

    sorted_key_node_table_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_key_hi       (s_key_hi),
        .s_key_mid      (s_key_mid),
        .s_key_lo       (s_key_lo),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_place        (m_place),
        .m_found        (m_found),
        .m_entry_total  (m_entry_total),
        .m_is_full_flag (m_is_full_flag),
        .m_rejected     (m_rejected)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned lower_bound_place_of(input node_key_t k);
        int unsigned base;
        int unsigned span;
        int unsigned half;
        base = 0;
        span = table_count;
        while (span > 0) begin
            half = span / 2;
            if (table_keys[base + half] < k) begin
                base = base + half + 1;
                span = span - half - 1;
            end else begin
                span = half;
            end
        end
        return base;
    endfunction

    function automatic result_t apply_node_item(input logic [1:0] op, input node_key_t k);
        result_t     res;
        int unsigned place;
        bit          was_full;
        res = '0;
        was_full = (table_count >= NODE_ORDER);
        place = (op == OP_APPEND) ? table_count : lower_bound_place_of(k);
        if (op == OP_INSERT || op == OP_APPEND) begin
            if (was_full) begin
                res.rejected = 1'b1;
            end else begin
                if (op == OP_INSERT) begin
                    for (int i = table_count; i > place; i--) table_keys[i] = table_keys[i - 1];
                end
                table_keys[place] = k;
                table_count++;
            end
        end else if (place < table_count) begin
            res.found = (table_keys[place] == k);
        end
        res.place        = OUT_W'(place);
        res.entry_total  = OUT_W'(table_count);
        res.is_full_flag = (table_count == NODE_ORDER);
        return res;
    endfunction

    // random key, extreme key, small key, or a stored key taken as is or nudged
    function automatic node_key_t pick_key();
        node_key_t   k;
        node_key_t   near;
        int unsigned mode;
        mode  = $urandom_range(9);
        k.hi  = {$urandom, $urandom};
        k.mid = {$urandom, $urandom};
        k.lo  = $urandom;
        if (mode == 1) begin
            k.hi  = $urandom_range(1) ? ALL64 : 64'h0;
            k.mid = $urandom_range(1) ? ALL64 : 64'h0;
            k.lo  = $urandom_range(1) ? ALL32 : 32'h0;
        end else if (mode == 9) begin
            k.hi  = 64'($urandom_range(3));
            k.mid = 64'($urandom_range(3));
            k.lo  = 32'($urandom_range(3));
        end else if (mode >= 2 && table_count > 0) begin
            near = table_keys[$urandom_range(table_count - 1)];
            case (mode)
                5: begin
                    near.lo = near.lo + 32'd1;
                end
                6: begin
                    near.lo = near.lo - 32'd1;
                end
                7: begin
                    near.mid = k.mid;
                end
                8: begin
                    near.mid = k.mid;
                    near.lo  = k.lo;
                end
                default: begin
                end
            endcase
            k = near;
        end
        return k;
    endfunction

    task automatic transfer_item(input logic [1:0] op, input node_key_t k,
                                 input logic typed, input result_t want);
        result_t     predicted;
        int unsigned gap;
        gap = 0;
        if (!stall_free) begin
            if ($urandom_range(99) < 3) begin
                gap = $urandom_range(30, 5);
            end else begin
                while ($urandom_range(99) < 14) gap++;
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_key_hi  <= k.hi;
        s_key_mid <= k.mid;
        s_key_lo  <= k.lo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_node_item(op, k);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    initial begin
        probe_row_t  row;
        logic [1:0]  op;
        int unsigned write_pct;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            row = DIRECTED_ROWS[r];
            transfer_item(row.op, row.key, row.typed, row.want);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            stall_free <= (n >= 600 && n < 900);
            write_pct = (table_count < NODE_ORDER) ? 4 : 15;
            if ($urandom_range(99) < write_pct) begin
                op = ($urandom_range(3) == 0) ? OP_APPEND : OP_INSERT;
            end else begin
                op = ($urandom_range(9) == 0) ? OP_UNUSED : OP_LOOKUP;
            end
            transfer_item(op, pick_key(), 1'b0, '0);
        end
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[sorted_key_node_table_core] OK");
        end else begin
            $display("[sorted_key_node_table_core] ERROR");
        end
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= stall_free || ($urandom_range(99) >= 14);
    end

    // result checker, one transfer per edge at most
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("result %0d: transfer with no expected result pending",
                             results_seen);
                end
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = pending_results.pop_front();
                if (m_place !== want.place || m_found !== want.found ||
                    m_entry_total !== want.entry_total ||
                    m_is_full_flag !== want.is_full_flag ||
                    m_rejected !== want.rejected) begin
                    if (mismatch_count < 10) begin
                        $display("result %0d: exp place %0d found %0b total %0d full %0b rej %0b",
                                 results_seen, want.place, want.found, want.entry_total,
                                 want.is_full_flag, want.rejected);
                        $display("result %0d: got place %0d found %0b total %0d full %0b rej %0b",
                                 results_seen, m_place, m_found, m_entry_total,
                                 m_is_full_flag, m_rejected);
                    end
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[sorted_key_node_table_core] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
+incdir+design
design/sknt_pkg.sv
design/sknt_key_ram.sv
design/sknt_seq.sv
design/sorted_key_node_table_core.sv
tb/sorted_key_node_table_core_tb.sv
